>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define JCMI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define JCMI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/jcmi_pkg.sv
// ----------------------------------------------------------------------------
// jcmi_pkg
// types and constants shared by the joint cosine move interpolator
// ----------------------------------------------------------------------------
package jcmi_pkg;

	localparam int ANGLE_W    = 24;
	localparam int MS_W       = 16;
	localparam int TICK_W     = 8;
	localparam int MAX_JOINTS = 7;

	// blend in q16, 65536 is one
	localparam int U_W = 17;
	localparam logic [U_W-1:0] U_ONE = 17'd65536;

	// shared multiplier operands
	localparam int MUL_A_W = 18;
	localparam int MUL_B_W = 26;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// bit-serial divider
	localparam int DIV_NUM_W = 34;
	localparam int DIV_Q_W   = 17;
	localparam int DIV_D_W   = MS_W;
	localparam int DIV_STEPS = DIV_Q_W;
	localparam int DIV_CNT_W = 5;

	// register map
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	localparam int PADDR_W   = 5;
	localparam logic [REG_IDX_W-1:0] REG_MOVE_TIME = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_0  = 3'd1;

	localparam logic [MS_W-1:0] MOVE_TIME_RESET = 16'd4000;
	localparam logic signed [ANGLE_W-1:0] TARGET_RESET [0:MAX_JOINTS-1] = '{
		-24'sd139, -24'sd823379, 24'sd281, -24'sd2470382,
		24'sd769, 24'sd1647509, 24'sd823243
	};

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_D_W-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_Q_W-1:0] quot;
		logic [DIV_D_W-1:0] rem;
	} div_rsp_t;

endpackage

>>> src/jcmi_div.sv
// ----------------------------------------------------------------------------
// jcmi_div
// restoring divider, one quotient bit per cycle, quotient below 2^17
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jcmi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  jcmi_pkg::div_req_t req,
	output jcmi_pkg::div_rsp_t rsp
);

	logic [jcmi_pkg::DIV_D_W-1:0]   rem_q;
	logic [jcmi_pkg::DIV_Q_W-1:0]   shf_q;
	logic [jcmi_pkg::DIV_D_W-1:0]   den_q;
	logic [jcmi_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [jcmi_pkg::DIV_D_W:0]     trial;
	logic [jcmi_pkg::DIV_D_W:0]     diff;
	logic                           ge;

	assign trial = {rem_q, shf_q[jcmi_pkg::DIV_Q_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == jcmi_pkg::DIV_CNT_W'(jcmi_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, partial remainder starts below the divisor
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[jcmi_pkg::DIV_NUM_W-2:jcmi_pkg::DIV_Q_W];
			shf_q <= req.num[jcmi_pkg::DIV_Q_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[jcmi_pkg::DIV_D_W-1:0] : trial[jcmi_pkg::DIV_D_W-1:0];
			shf_q <= {shf_q[jcmi_pkg::DIV_Q_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = shf_q;
	assign rsp.rem  = rem_q;

	`JCMI_ASSERT(a_div_no_restart, req.start |-> !busy_q, "divider restarted while busy")
	`JCMI_ASSERT(a_div_rem_bound, done_q |-> (rem_q < den_q), "remainder not below divisor")

endmodule

>>> src/jcmi_mul.sv
// ----------------------------------------------------------------------------
// jcmi_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module jcmi_mul (
	input  logic                                clk,
	input  logic signed [jcmi_pkg::MUL_A_W-1:0] a,
	input  logic signed [jcmi_pkg::MUL_B_W-1:0] b,
	output logic signed [jcmi_pkg::MUL_P_W-1:0] p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

>>> src/jcmi_rom.sv
// ----------------------------------------------------------------------------
// jcmi_rom
// raised-cosine blend table in q16, built at elaboration, registered read
// ----------------------------------------------------------------------------
module jcmi_rom #(
	parameter int COS_TABLE_DEPTH = 256
) (
	input  logic                                 clk,
	input  logic [$clog2(COS_TABLE_DEPTH+1)-1:0] addr,
	output logic [jcmi_pkg::U_W-1:0]             data
);

	localparam int    AW      = $clog2(COS_TABLE_DEPTH + 1);
	localparam int    ROM_N   = 2 ** AW;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint PI_Q30  = 64'sd3373259426;

	function automatic longint clamp_q30(input longint x);
		longint r;
		r = x;
		if (x < 0)
			r = 0;
		else if (x > ONE_Q30)
			r = ONE_Q30;
		return r;
	endfunction

	// taylor series of cos in q30 on [0, pi/2], horner form
	function automatic longint cos_quarter(input longint a);
		longint a2;
		longint t;
		a2 = (a * a) >>> 30;
		t  = ONE_Q30;
		t  = clamp_q30(ONE_Q30 - ((a2 * t) >>> 30) / 132);
		t  = clamp_q30(ONE_Q30 - ((a2 * t) >>> 30) / 90);
		t  = clamp_q30(ONE_Q30 - ((a2 * t) >>> 30) / 56);
		t  = clamp_q30(ONE_Q30 - ((a2 * t) >>> 30) / 30);
		t  = clamp_q30(ONE_Q30 - ((a2 * t) >>> 30) / 12);
		t  = clamp_q30(ONE_Q30 - ((a2 * t) >>> 30) / 2);
		return t;
	endfunction

	function automatic logic [jcmi_pkg::U_W-1:0] rom_entry(input longint k);
		longint kk;
		longint half;
		kk = (k > COS_TABLE_DEPTH) ? longint'(COS_TABLE_DEPTH) : k;
		if (2 * kk <= COS_TABLE_DEPTH)
			half = (ONE_Q30 - cos_quarter((PI_Q30 * kk) / COS_TABLE_DEPTH)) / 2;
		else
			half = (ONE_Q30 + cos_quarter((PI_Q30 * (COS_TABLE_DEPTH - kk))
				/ COS_TABLE_DEPTH)) / 2;
		return jcmi_pkg::U_W'((half + 8192) >>> 14);
	endfunction

	logic [jcmi_pkg::U_W-1:0] tbl [0:ROM_N-1];

	for (genvar g = 0; g < ROM_N; g++) begin : g_tbl
		localparam logic [jcmi_pkg::U_W-1:0] ENTRY = rom_entry(longint'(g));
		assign tbl[g] = ENTRY;
	end

	always_ff @(posedge clk) begin
		data <= tbl[addr];
	end

endmodule

>>> src/joint_cosine_move_interpolator.sv
// ----------------------------------------------------------------------------
// joint_cosine_move_interpolator
// raised-cosine joint move interpolator: one request per control tick gives
// one set of blended joint commands plus a move-finished flag
// ----------------------------------------------------------------------------
//  port group | dir | carries
//  -----------+-----+--------------------------------------------------------
//  s_*        | in  | tick request: tick_ms, now_0..now_6
//  m_*        | out | result request: cmd_0..cmd_6, move_done on m_tlast
//  p*         | in  | apb registers: move_time_ms at 0x00, target_i at 4*(i+1)
//
//  a tick inside a move makes two passes of the bit-serial divider, two table
//  reads, and a multiply and a rounding step per joint on the shared
//  multiplier
//  a tick that finishes the move skips the blend and goes straight to the joints
//  reset clears elapsed time, arms start capture and loads the register
//  defaults; no clearing pass is needed
//  a stalled m_tready holds the finished result in the output register while
//  the next request is already being worked; s_tready stays low while busy
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module joint_cosine_move_interpolator #(
	parameter int JOINT_COUNT     = 7,
	parameter int COS_TABLE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// tick_ms [7:0], now_0 [31:8] ... now_6 [175:152]
	input  logic [175:0]                   s_tdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// cmd_0 [23:0] ... cmd_6 [167:144]
	output logic [167:0]                   m_tdata,
	output logic                           m_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [jcmi_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam int AW = jcmi_pkg::ANGLE_W;
	localparam int JN = (JOINT_COUNT < jcmi_pkg::MAX_JOINTS) ? JOINT_COUNT
		: jcmi_pkg::MAX_JOINTS;
	localparam int JW = (JN > 1) ? $clog2(JN) : 1;
	localparam int KW = $clog2(COS_TABLE_DEPTH + 1);

	// sequencer codes
	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_NMUL      = 4'd1;
	localparam logic [3:0] ST_DIVK_GO   = 4'd2;
	localparam logic [3:0] ST_DIVK_WAIT = 4'd3;
	localparam logic [3:0] ST_ROM_LO    = 4'd4;
	localparam logic [3:0] ST_ROM_HI    = 4'd5;
	localparam logic [3:0] ST_FMUL      = 4'd6;
	localparam logic [3:0] ST_DIVF_GO   = 4'd7;
	localparam logic [3:0] ST_DIVF_WAIT = 4'd8;
	localparam logic [3:0] ST_JMUL      = 4'd9;
	localparam logic [3:0] ST_JRND      = 4'd10;
	localparam logic [3:0] ST_OUT       = 4'd11;

	logic [3:0]                    state_q;

	// configuration
	logic [jcmi_pkg::MS_W-1:0]     move_time_q;
	logic signed [AW-1:0]          target_q [0:JN-1];

	// move state
	logic [jcmi_pkg::MS_W-1:0]     elapsed_q;
	logic                          awaiting_q;
	logic signed [AW-1:0]          start_q [0:JN-1];

	// per-tick working registers
	logic [jcmi_pkg::MS_W-1:0]     e_q;
	logic                          mdone_q;
	logic [KW-1:0]                 k_q;
	logic [jcmi_pkg::DIV_D_W-1:0]  r_q;
	logic [jcmi_pkg::U_W-1:0]      lo_q;
	logic [jcmi_pkg::U_W-1:0]      u_q;
	logic [JW-1:0]                 jidx_q;
	logic signed [AW-1:0]          res_q [0:JN-1];

	// output register
	logic                          m_tvalid_q;
	logic                          m_tlast_q;
	logic [167:0]                  m_tdata_q;
	logic [167:0]                  cmd_next;

	// apb decode
	logic                          cfg_wr;
	logic [jcmi_pkg::REG_IDX_W-1:0] cfg_idx;
	logic [31:0]                   cfg_rd [0:jcmi_pkg::NUM_REGS-1];

	// shared units
	logic signed [jcmi_pkg::MUL_A_W-1:0] mul_a;
	logic signed [jcmi_pkg::MUL_B_W-1:0] mul_b;
	logic signed [jcmi_pkg::MUL_P_W-1:0] mul_p;
	jcmi_pkg::div_req_t            div_req;
	jcmi_pkg::div_rsp_t            div_rsp;
	logic [KW-1:0]                 rom_addr;
	logic [jcmi_pkg::U_W-1:0]      rom_data;

	// tick arithmetic at accept
	logic                          in_acc;
	logic [jcmi_pkg::MS_W:0]       sum_ms;
	logic [jcmi_pkg::MS_W-1:0]     e_new;
	logic                          done_new;

	// joint rounding
	logic signed [AW:0]            jdiff;
	logic                          p_neg;
	logic [jcmi_pkg::MUL_P_W-1:0]  p_mag;
	logic [jcmi_pkg::MUL_P_W-1:0]  p_rnd;
	logic signed [AW+2:0]          q_rnd;
	logic signed [AW+2:0]          cmd_w;

	logic                          out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// elapsed time saturates at the move time, also after a lowered move time
	assign sum_ms   = {1'b0, elapsed_q} + {{(jcmi_pkg::MS_W - jcmi_pkg::TICK_W + 1){1'b0}},
		s_tdata[jcmi_pkg::TICK_W-1:0]};
	assign e_new    = (sum_ms > {1'b0, move_time_q}) ? move_time_q
		: sum_ms[jcmi_pkg::MS_W-1:0];
	assign done_new = (e_new >= move_time_q);

	// ---------------- apb ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[jcmi_pkg::PADDR_W-1:2];

	assign cfg_rd[0] = {{(32 - jcmi_pkg::MS_W){1'b0}}, move_time_q};
	for (genvar g = 1; g < jcmi_pkg::NUM_REGS; g++) begin : g_rd
		if (g - 1 < JN) begin : g_have
			assign cfg_rd[g] = {{(32 - AW){target_q[g-1][AW-1]}}, target_q[g-1]};
		end else begin : g_none
			assign cfg_rd[g] = '0;
		end
	end
	assign prdata = cfg_rd[cfg_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_time_q <= jcmi_pkg::MOVE_TIME_RESET;
			for (int j = 0; j < JN; j++)
				target_q[j] <= jcmi_pkg::TARGET_RESET[j];
		end else if (cfg_wr) begin
			if (cfg_idx == jcmi_pkg::REG_MOVE_TIME)
				move_time_q <= pwdata[jcmi_pkg::MS_W-1:0];
			for (int j = 0; j < JN; j++)
				if (cfg_idx == jcmi_pkg::REG_IDX_W'(jcmi_pkg::REG_TARGET_0 + j))
					target_q[j] <= pwdata[AW-1:0];
		end
	end

	// ---------------- shared unit operands ----------------
	assign jdiff = {target_q[jidx_q][AW-1], target_q[jidx_q]}
		- {start_q[jidx_q][AW-1], start_q[jidx_q]};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_NMUL: begin
				// table position scaled by the table depth
				mul_a = $signed({{(jcmi_pkg::MUL_A_W - jcmi_pkg::MS_W){1'b0}}, e_q});
				mul_b = jcmi_pkg::MUL_B_W'(COS_TABLE_DEPTH);
			end
			ST_FMUL: begin
				// table step times the fraction remainder
				mul_a = $signed({1'b0, rom_data - lo_q});
				mul_b = $signed({{(jcmi_pkg::MUL_B_W - jcmi_pkg::DIV_D_W){1'b0}}, r_q});
			end
			ST_JMUL: begin
				mul_a = $signed({1'b0, u_q});
				mul_b = {{(jcmi_pkg::MUL_B_W - AW - 1){jdiff[AW]}}, jdiff};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_req.start = (state_q == ST_DIVK_GO) || (state_q == ST_DIVF_GO);
	assign div_req.num   = mul_p[jcmi_pkg::DIV_NUM_W-1:0];
	assign div_req.den   = move_time_q;

	assign rom_addr = (state_q == ST_ROM_HI) ? k_q + 1'b1 : k_q;

	jcmi_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	jcmi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	jcmi_rom #(
		.COS_TABLE_DEPTH (COS_TABLE_DEPTH)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	// round half away from zero of u*diff / 2^16
	assign p_neg = mul_p[jcmi_pkg::MUL_P_W-1];
	assign p_mag = p_neg ? jcmi_pkg::MUL_P_W'(-mul_p) : jcmi_pkg::MUL_P_W'(mul_p);
	assign p_rnd = (p_mag + jcmi_pkg::MUL_P_W'(32768)) >> 16;
	assign q_rnd = p_neg ? -$signed({1'b0, p_rnd[AW+1:0]}) : $signed({1'b0, p_rnd[AW+1:0]});
	assign cmd_w = {{3{start_q[jidx_q][AW-1]}}, start_q[jidx_q]} + q_rnd;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			elapsed_q  <= '0;
			awaiting_q <= 1'b1;
			jidx_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						jidx_q     <= '0;
						// done re-arms the block for the next move
						elapsed_q  <= done_new ? '0 : e_new;
						awaiting_q <= done_new;
						state_q    <= done_new ? ST_JMUL : ST_NMUL;
					end
				end
				ST_NMUL:      state_q <= ST_DIVK_GO;
				ST_DIVK_GO:   state_q <= ST_DIVK_WAIT;
				ST_DIVK_WAIT: if (div_rsp.done) state_q <= ST_ROM_LO;
				ST_ROM_LO:    state_q <= ST_ROM_HI;
				ST_ROM_HI:    state_q <= ST_FMUL;
				ST_FMUL:      state_q <= ST_DIVF_GO;
				ST_DIVF_GO:   state_q <= ST_DIVF_WAIT;
				ST_DIVF_WAIT: if (div_rsp.done) state_q <= ST_JMUL;
				ST_JMUL:      state_q <= ST_JRND;
				ST_JRND: begin
					if (jidx_q == JW'(JN - 1)) begin
						state_q <= ST_OUT;
					end else begin
						jidx_q  <= jidx_q + 1'b1;
						state_q <= ST_JMUL;
					end
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			e_q     <= e_new;
			mdone_q <= done_new;
			u_q     <= jcmi_pkg::U_ONE;
			// first tick of a move captures the start angles
			if (awaiting_q)
				for (int j = 0; j < JN; j++)
					start_q[j] <= s_tdata[jcmi_pkg::TICK_W + AW*j +: AW];
		end
		if (state_q == ST_DIVK_WAIT && div_rsp.done) begin
			k_q <= div_rsp.quot[KW-1:0];
			r_q <= div_rsp.rem;
		end
		if (state_q == ST_ROM_HI)
			lo_q <= rom_data;
		if (state_q == ST_DIVF_WAIT && div_rsp.done)
			u_q <= lo_q + div_rsp.quot;
		if (state_q == ST_JRND)
			res_q[jidx_q] <= cmd_w[AW-1:0];
	end

	// ---------------- output register ----------------
	for (genvar g = 0; g < jcmi_pkg::MAX_JOINTS; g++) begin : g_out
		if (g < JN) begin : g_have
			assign cmd_next[AW*g +: AW] = res_q[g];
		end else begin : g_none
			assign cmd_next[AW*g +: AW] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= cmd_next;
			m_tlast_q <= mdone_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`JCMI_ASSERT_NEXT(a_busy_after_request, in_acc, state_q != ST_IDLE,
		"block still ready right after taking a request")
	`JCMI_ASSERT(a_blend_range, (state_q == ST_JMUL) |-> (u_q <= jcmi_pkg::U_ONE),
		"blend above one")
	`JCMI_ASSERT(a_rearm_on_done,
		(state_q == ST_OUT && mdone_q) |-> (awaiting_q && elapsed_q == '0),
		"finished move did not re-arm")

endmodule

>>> tb/tb_joint_cosine_move_interpolator.sv
// ----------------------------------------------------------------------------
// tb_joint_cosine_move_interpolator
// streams control ticks and apb register writes into the joint move
// interpolator, predicts each raised-cosine command set in the scoreboard and
// compares it field by field, under random idling on both stream sides
// ----------------------------------------------------------------------------

// one tick request as packed on s_tdata
typedef struct packed {
	logic [jcmi_pkg::MAX_JOINTS-1:0][jcmi_pkg::ANGLE_W-1:0] now;
	logic [jcmi_pkg::TICK_W-1:0]                            tick_ms;
} tick_req_t;

// one result request: move_done on m_tlast above the m_tdata commands
typedef struct packed {
	logic                                                   done;
	logic [jcmi_pkg::MAX_JOINTS-1:0][jcmi_pkg::ANGLE_W-1:0] cmd;
} joint_cmd_t;

class joint_cmd_scoreboard;
	localparam int LUT_DEPTH = 256;
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	longint     half_cos_lut [LUT_DEPTH+1];
	longint     move_time;
	longint     goal [jcmi_pkg::MAX_JOINTS];
	longint     origin [jcmi_pkg::MAX_JOINTS];
	longint     elapsed;
	bit         arm_start;
	joint_cmd_t expected_cmds [$];
	int         mismatches;

	function new();
		for (int k = 0; k <= LUT_DEPTH; k++)
			half_cos_lut[k] = lut_entry(k);
		move_time = jcmi_pkg::MOVE_TIME_RESET;
		for (int j = 0; j < jcmi_pkg::MAX_JOINTS; j++) begin
			goal[j]   = jcmi_pkg::TARGET_RESET[j];
			origin[j] = 0;
		end
		elapsed    = 0;
		arm_start  = 1;
		mismatches = 0;
	endfunction

	// cos in q30 on [0, pi/2], horner form with every partial clamped to [0, 1]
	function longint quarter_cos(longint unsigned ang);
		longint sq;
		longint acc;
		int     i;
		sq  = longint'((ang * ang) >> 30);
		acc = Q30_ONE;
		for (i = 0; i < 6; i++) begin
			acc = Q30_ONE - ((sq * acc) >>> 30) / longint'((12 - 2*i) * (11 - 2*i));
			if (acc < 0)
				acc = 0;
			if (acc > Q30_ONE)
				acc = Q30_ONE;
		end
		return acc;
	endfunction

	// blend table entry in q16, upper half mirrored
	function longint lut_entry(int k);
		longint          half;
		longint unsigned kk;
		kk = k;
		if (2*k <= LUT_DEPTH)
			half = (Q30_ONE - quarter_cos((PI_Q30 * kk) / LUT_DEPTH)) / 2;
		else
			half = (Q30_ONE + quarter_cos((PI_Q30 * (LUT_DEPTH - kk)) / LUT_DEPTH)) / 2;
		return (half + 8192) >>> 14;
	endfunction

	function longint blend_at(longint t);
		longint n;
		longint k;
		longint r;
		if (t >= move_time)
			return 65536;
		n = t * LUT_DEPTH;
		k = n / move_time;
		r = n % move_time;
		return half_cos_lut[k] +
			((half_cos_lut[k+1] - half_cos_lut[k]) * r) / move_time;
	endfunction

	function void set_reg(int idx, logic [31:0] value);
		if (idx == jcmi_pkg::REG_MOVE_TIME)
			move_time = value[15:0];
		else if (idx < jcmi_pkg::NUM_REGS)
			goal[idx - jcmi_pkg::REG_TARGET_0] = longint'($signed(value[23:0]));
	endfunction

	function void note_tick(tick_req_t req);
		joint_cmd_t res;
		longint     u;
		longint     diff;
		longint     p;
		longint     q;
		longint     c;
		if (arm_start) begin
			for (int j = 0; j < jcmi_pkg::MAX_JOINTS; j++)
				origin[j] = longint'($signed(req.now[j]));
			arm_start = 0;
		end
		elapsed = elapsed + req.tick_ms;
		if (elapsed > move_time)
			elapsed = move_time;
		res.done = (elapsed >= move_time);
		u = blend_at(elapsed);
		for (int j = 0; j < jcmi_pkg::MAX_JOINTS; j++) begin
			diff = goal[j] - origin[j];
			p = u * diff;
			if (p >= 0)
				q = (p + 32768) >>> 16;
			else
				q = -((-p + 32768) >>> 16);
			c = origin[j] + q;
			res.cmd[j] = c[23:0];
		end
		expected_cmds.insert(expected_cmds.size(), res);
		if (res.done) begin
			arm_start = 1;
			elapsed   = 0;
		end
	endfunction

	function void note_mismatch(string what, longint want, longint got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
	endfunction

	function void check_cmds(joint_cmd_t got);
		joint_cmd_t want;
		if (expected_cmds.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("command set with none pending: cmd_0 %0d done %0d",
					$signed(got.cmd[0]), got.done);
			return;
		end
		want = expected_cmds.pop_front();
		for (int j = 0; j < jcmi_pkg::MAX_JOINTS; j++)
			if (got.cmd[j] !== want.cmd[j])
				note_mismatch($sformatf("cmd_%0d", j), longint'($signed(want.cmd[j])),
					longint'($signed(got.cmd[j])));
		if (got.done !== want.done)
			note_mismatch("move_done", want.done, got.done);
	endfunction

	function int pending();
		return expected_cmds.size();
	endfunction
endclass

module tb_joint_cosine_move_interpolator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int JOINTS      = 7;
	localparam int COS_DEPTH   = 256;
	localparam int TICK_GOAL   = 1050;
	localparam int HOLD_CYCLES = 1500;
	// worst tick: its busy time plus the longest idle_len gap and the longest stall,
	// taken about six times over for 1050 ticks
	localparam int unsigned CYCLE_LIMIT = 1_500_000;

	logic                          clk;
	logic                          arst_n;
	logic [175:0]                  s_tdata;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [167:0]                  m_tdata;
	logic                          m_tlast;
	logic                          m_tvalid;
	logic                          m_tready;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [jcmi_pkg::PADDR_W-1:0]  paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;

	joint_cmd_scoreboard board;
	int unsigned         cycle_count = 0;
	int                  ticks_in;
	bit                  hold_off;
	bit                  src_quiet;
	bit                  press_go;

	joint_cosine_move_interpolator #(
		.JOINT_COUNT     (JOINTS),
		.COS_TABLE_DEPTH (COS_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),   // tick_ms [7:0], now_0 [31:8] ... now_6 [175:152]
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),   // cmd_0 [23:0] ... cmd_6 [167:144]
		.m_tlast  (m_tlast),   // move_done
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// run guard
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// mostly back to back, sometimes a few cycles, rarely a long gap
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// full range with the two extremes weighted up
	function automatic logic [23:0] rand_angle();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 24'h800000;
		if (r == 1)
			return 24'h7fffff;
		return 24'($urandom());
	endfunction

	function automatic logic [31:0] sext_angle(logic [23:0] a);
		return {{8{a[23]}}, a};
	endfunction

	// short moves dominate so most moves finish inside a phase
	function automatic logic [15:0] rand_move_time();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 16'd0;
		if (r == 1)
			return 16'd1;
		if (r == 2)
			return 16'hffff;
		if (r < 10)
			return 16'($urandom_range(2, 400));
		if (r < 18)
			return 16'($urandom_range(400, 4000));
		return 16'($urandom_range(4000, 65535));
	endfunction

	function automatic tick_req_t rand_tick();
		tick_req_t req;
		int        r;
		r = $urandom_range(0, 9);
		if (r == 0)
			req.tick_ms = 8'd0;
		else if (r == 1)
			req.tick_ms = 8'd255;
		else if (r < 4)
			req.tick_ms = 8'($urandom_range(0, 15));
		else
			req.tick_ms = 8'($urandom());
		for (int j = 0; j < jcmi_pkg::MAX_JOINTS; j++)
			req.now[j] = rand_angle();
		return req;
	endfunction

	function automatic tick_req_t fixed_tick(logic [7:0] ms, logic [23:0] even_now,
		logic [23:0] odd_now);
		tick_req_t req;
		req.tick_ms = ms;
		for (int j = 0; j < jcmi_pkg::MAX_JOINTS; j++)
			req.now[j] = (j % 2 == 0) ? even_now : odd_now;
		return req;
	endfunction

	// one tick request; valid stays up between back-to-back requests
	task automatic send_tick(tick_req_t req);
		int gap;
		gap = src_quiet ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= req;
		do @(posedge clk); while (!s_tready);
		board.note_tick(req);
		ticks_in++;
	endtask

	// setup cycle, access cycle, then an idle cycle so psel drops cleanly
	task automatic reg_write(int idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= jcmi_pkg::PADDR_W'(idx * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.set_reg(idx, value);
		@(posedge clk);
	endtask

	// every tick yields one result, so an empty store means the block is idle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_targets(logic [23:0] even_goal, logic [23:0] odd_goal);
		for (int j = 0; j < jcmi_pkg::MAX_JOINTS; j++)
			reg_write(int'(jcmi_pkg::REG_TARGET_0) + j,
				sext_angle((j % 2 == 0) ? even_goal : odd_goal));
	endtask

	// result side: check accepted commands, then pick the next ready value
	initial begin
		int stall;
		bit quiet;
		stall    = 0;
		quiet    = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				board.check_cmds({m_tlast, m_tdata});
			// some stretches with no stalls at all
			if (cycle_count % 512 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (hold_off) begin
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0)
					stall = idle_len();
			end
		end
	end

	// long receiver hold-off while ticks keep coming, so s_tready must drop
	initial begin
		hold_off <= 1'b0;
		wait (press_go);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		int n;
		board     = new();
		ticks_in  = 0;
		src_quiet = 0;
		press_go  = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: start latched at the negative extreme, then mid-move
		// ticks whose positions must be ignored
		send_tick(fixed_tick(8'd0, 24'h800000, 24'h800000));
		send_tick(fixed_tick(8'd255, 24'h7fffff, 24'h7fffff));
		send_tick(fixed_tick(8'd255, 24'h7fffff, 24'h800000));
		send_tick(fixed_tick(8'd1, 24'h000000, 24'hffffff));
		send_tick(fixed_tick(8'd128, 24'h555555, 24'haaaaaa));

		// move time lowered mid-move: the next tick finishes the move
		wait_drained();
		reg_write(int'(jcmi_pkg::REG_MOVE_TIME), 32'd1);
		write_targets(24'h7fffff, 24'h800000);
		send_tick(fixed_tick(8'd0, 24'h123456, 24'hedcba9));
		// widest span: start at the opposite extreme of each target
		send_tick(fixed_tick(8'd0, 24'h800000, 24'h7fffff));
		send_tick(fixed_tick(8'd1, 24'h000000, 24'h000000));

		// zero move time: every tick finishes a move on its own
		wait_drained();
		reg_write(int'(jcmi_pkg::REG_MOVE_TIME), 32'd0);
		send_tick(fixed_tick(8'd0, 24'h7fffff, 24'h800000));
		send_tick(fixed_tick(8'd255, 24'h800000, 24'h7fffff));

		// longest move time, targets swapped
		wait_drained();
		reg_write(int'(jcmi_pkg::REG_MOVE_TIME), 32'hffff);
		write_targets(24'h800000, 24'h7fffff);
		send_tick(fixed_tick(8'd255, 24'h7fffff, 24'h800000));
		send_tick(fixed_tick(8'd255, 24'h000000, 24'h000000));
		send_tick(fixed_tick(8'd255, 24'h000000, 24'h000000));
		send_tick(fixed_tick(8'd0, 24'h000000, 24'h000000));

		// lowered again, then a move that lands on the second-to-last table interval
		wait_drained();
		reg_write(int'(jcmi_pkg::REG_MOVE_TIME), 32'd255);
		send_tick(fixed_tick(8'd255, 24'h000000, 24'h000000));
		send_tick(fixed_tick(8'd255, 24'h400000, 24'hc00000));
		send_tick(fixed_tick(8'd254, 24'h7fffff, 24'h800000));
		send_tick(fixed_tick(8'd1, 24'h000000, 24'h000000));

		// random phases: random register writes between phases, moves may span phases
		while (ticks_in < TICK_GOAL) begin
			wait_drained();
			if ($urandom_range(0, 3) != 0)
				reg_write(int'(jcmi_pkg::REG_MOVE_TIME), {16'd0, rand_move_time()});
			for (int j = 0; j < jcmi_pkg::MAX_JOINTS; j++)
				if ($urandom_range(0, 1) == 1)
					reg_write(int'(jcmi_pkg::REG_TARGET_0) + j, sext_angle(rand_angle()));
			src_quiet = ($urandom_range(0, 3) == 0);
			n = $urandom_range(10, 60);
			// one phase keeps offering ticks back to back while the receiver holds off
			if (!press_go && ticks_in >= 200) begin
				press_go  = 1'b1;
				src_quiet = 1'b1;
				n         = 40;
			end
			repeat (n) send_tick(rand_tick());
		end

		wait_drained();
		repeat (60) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
